[hw/rtl/sppm_pkg.sv]
// Package for the speed pulse period monitor.
// Constants, register indexes, report kinds and the shared struct types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sppm_pkg;

  localparam int ENTRY_SLOTS_DEF = 32;
  localparam int AVG_COUNT_DEF   = 6;

  localparam int TIMER_W = 10;
  localparam int MARK_W  = 24;
  localparam int COUNT_W = 7;
  localparam int DELTA_W = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W  = 1;
  localparam int CFG_AW  = 5;

  localparam logic [DELTA_W-1:0] DELTA_CAP = 6'd32;

  localparam logic [1:0] KIND_LIFE  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_AVG   = 2'd2;

  localparam logic [2:0] REG_AVG_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_STOP_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_SEND_INTERVAL = 3'd2;
  localparam logic [2:0] REG_LIFE_INTERVAL = 3'd3;
  localparam logic [2:0] REG_STOP_MARKER   = 3'd4;
  localparam logic [2:0] REG_STOP_FILL     = 3'd5;

  localparam logic [TIMER_W-1:0] RST_AVG_INTERVAL  = 10'd20;
  localparam logic [TIMER_W-1:0] RST_STOP_TIMEOUT  = 10'd750;
  localparam logic [TIMER_W-1:0] RST_SEND_INTERVAL = 10'd50;
  localparam logic [TIMER_W-1:0] RST_LIFE_INTERVAL = 10'd5;
  localparam logic [MARK_W-1:0]  RST_STOP_MARKER   = 24'h000000;
  localparam logic [MARK_W-1:0]  RST_STOP_FILL     = 24'hFFFFFF;

  typedef struct packed {
    logic [TIMER_W-1:0] avg_interval;
    logic [TIMER_W-1:0] stop_timeout;
    logic [TIMER_W-1:0] send_interval;
    logic [TIMER_W-1:0] life_interval;
    logic [MARK_W-1:0]  stop_marker;
    logic [MARK_W-1:0]  stop_fill;
  } cfg_t;

  typedef struct packed {
    logic               have_life;
    logic [15:0]        life_val;
    logic               have_avg;
    logic [31:0]        avg_val;
    logic               have_send;
    logic [COUNT_W-1:0] send_count;
    logic               bank;
    logic [31:0]        latest;
  } desc_t;

endpackage
`default_nettype wire

[hw/rtl/sppm_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sppm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/sppm_queue.sv]
// Short descriptor queue between the front and back parts.
// Depends on sppm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sppm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  sppm_pkg::desc_t    din,
  output logic               full,
  input  wire logic          pop,
  output sppm_pkg::desc_t    dout,
  output logic               empty
);
  sppm_pkg::desc_t mem_r [sppm_pkg::QUEUE_DEPTH];
  logic [sppm_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [sppm_pkg::QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (sppm_pkg::QPTR_W+1)'(sppm_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (sppm_pkg::QPTR_W+1)'(push) - (sppm_pkg::QPTR_W+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sppm_front.sv]
// Front part: accepts sample words, updates period, timer and averaging state,
// fills the period entry buffer and queues a report descriptor when one is due.
// Depends on sppm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sppm_front #(
  parameter int ENTRY_SLOTS = sppm_pkg::ENTRY_SLOTS_DEF,
  parameter int AVG_COUNT   = sppm_pkg::AVG_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_captured,
  input  wire logic        in_overflow,
  input  wire logic [15:0] in_edges,
  input  sppm_pkg::cfg_t   cfg,
  output logic             q_push,
  output sppm_pkg::desc_t  q_desc,
  input  wire logic        q_full,
  input  wire logic        send_done,
  output logic             ram_we,
  output logic [((ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1):0] ram_waddr,
  output logic [31:0]      ram_wdata
);
  localparam int SW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int CW = $clog2(ENTRY_SLOTS + 1);
  localparam int UW = $clog2(AVG_COUNT + 1);
  localparam int DW = sppm_pkg::DELTA_W;
  localparam int TW = sppm_pkg::TIMER_W;
  localparam int RL = $clog2(AVG_COUNT);
  localparam logic [63:0] RECIP =
    ((64'd1 << (32 + RL)) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_EDGE, S_FILL, S_EVT, S_DIV, S_PUSH} state_t;

  function automatic logic [DW-1:0] edge_delta(input logic [15:0] old, input logic [15:0] now);
    logic [15:0] d;
    d = old - now;
    edge_delta = (d >= 16'(sppm_pkg::DELTA_CAP)) ? sppm_pkg::DELTA_CAP : DW'(d);
  endfunction

  state_t          state_r;
  logic [15:0]     cap_r, cnt_r;
  logic            ovfin_r;
  logic [7:0]      ovf_cnt_r;
  logic [15:0]     prev_slow_r, prev_fast_r;
  logic [CW-1:0]   used_r;
  logic [31:0]     latest_r;
  logic [UW-1:0]   avg_used_r;
  logic [31:0]     avg_sum_r;
  logic            moving_r;
  logic [TW-1:0]   t_avg_r, t_stop_r, t_send_r, t_life_r;
  logic            phase_r;
  logic [15:0]     life_acc_r;
  logic [DW-1:0]   fill_left_r;
  logic [31:0]     val_r;
  logic            bank_r;
  logic            inflight_r;
  sppm_pkg::desc_t desc_r;
  logic [31:0]     div_x_r;
  logic [47:0]     div_lo_r;
  logic            div_step_r;

  logic [DW-1:0]   d_slow, d_fast;
  logic [7:0]      ovf_inc;
  logic [31:0]     val;
  logic [15:0]     life_sum;
  logic            avg_fire, send_fire, fill_go;
  logic [TW-1:0]   t_avg_z, t_send_z;
  logic [31:0]     sample, sum_n;
  logic            is_stop, moving_n;
  logic [UW-1:0]   used_inc;
  logic [47:0]     prod_lo;
  logic [48:0]     prod_hi;
  logic [64:0]     prod_sum;

  assign d_slow   = edge_delta(prev_slow_r, cnt_r);
  assign d_fast   = edge_delta(prev_fast_r, cnt_r);
  assign ovf_inc  = (ovfin_r && ovf_cnt_r != 8'hFF) ? ovf_cnt_r + 8'd1 : ovf_cnt_r;
  assign val      = (32'(ovf_inc) << 16) - 32'(ovf_inc) + 32'(cap_r) + 32'd1;
  assign life_sum = life_acc_r + 16'(d_fast);
  assign avg_fire  = (t_avg_r >= cfg.avg_interval);
  assign send_fire = (t_send_r >= cfg.send_interval);
  assign t_avg_z  = avg_fire ? '0 : t_avg_r;
  assign t_send_z = send_fire ? '0 : t_send_r;
  assign is_stop  = (latest_r == 32'(cfg.stop_marker));
  assign sample   = is_stop ? 32'(cfg.stop_fill) : latest_r;
  assign sum_n    = avg_sum_r + sample;
  assign moving_n = moving_r | !is_stop;
  assign used_inc = avg_used_r + UW'(1);
  assign prod_lo  = 48'(div_x_r) * 48'(RECIP[15:0]);
  assign prod_hi  = 49'(div_x_r) * 49'(RECIP[32:16]);
  assign prod_sum = 65'(div_lo_r) + {prod_hi, 16'h0000};

  assign in_ready  = (state_r == S_IDLE) && !q_full;
  assign fill_go   = (fill_left_r != '0) && (used_r < CW'(ENTRY_SLOTS));
  assign ram_we    = (state_r == S_FILL) && fill_go;
  assign ram_waddr = {bank_r, used_r[SW-1:0]};
  assign ram_wdata = val_r;
  assign q_push    = (state_r == S_PUSH) &&
                     (desc_r.have_life || desc_r.have_avg || desc_r.have_send);
  assign q_desc    = desc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ovf_cnt_r   <= '0;
      prev_slow_r <= 16'hFFFF;
      prev_fast_r <= 16'hFFFF;
      used_r      <= '0;
      latest_r    <= 32'(sppm_pkg::RST_STOP_MARKER);
      avg_used_r  <= '0;
      avg_sum_r   <= '0;
      moving_r    <= 1'b0;
      t_avg_r     <= '0;
      t_stop_r    <= '0;
      t_send_r    <= '0;
      t_life_r    <= '0;
      phase_r     <= 1'b1;
      life_acc_r  <= '0;
      fill_left_r <= '0;
      bank_r      <= 1'b0;
      inflight_r  <= 1'b0;
    end else begin
      if (send_done) begin
        inflight_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cap_r   <= in_captured;
            ovfin_r <= in_overflow;
            cnt_r   <= in_edges;
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (!phase_r) begin
            if (prev_slow_r == cnt_r) begin
              ovf_cnt_r   <= ovf_inc;
              fill_left_r <= '0;
              if (used_r < CW'(ENTRY_SLOTS) && t_stop_r >= cfg.stop_timeout) begin
                latest_r <= 32'(cfg.stop_marker);
              end
            end else begin
              val_r       <= val;
              fill_left_r <= d_slow;
              latest_r    <= val;
              ovf_cnt_r   <= '0;
              t_stop_r    <= '0;
            end
            prev_slow_r <= cnt_r;
          end else begin
            ovf_cnt_r   <= ovf_inc;
            fill_left_r <= '0;
          end
          phase_r <= !phase_r;
          if (t_life_r >= cfg.life_interval) begin
            desc_r.have_life <= 1'b1;
            desc_r.life_val  <= life_sum;
            life_acc_r       <= '0;
            t_life_r         <= '0;
          end else begin
            desc_r.have_life <= 1'b0;
            life_acc_r       <= life_sum;
          end
          prev_fast_r      <= cnt_r;
          desc_r.have_avg  <= 1'b0;
          desc_r.have_send <= 1'b0;
          state_r          <= S_FILL;
        end
        S_FILL: begin
          if (fill_go) begin
            used_r      <= used_r + CW'(1);
            fill_left_r <= fill_left_r - DW'(1);
          end else begin
            state_r <= S_EVT;
          end
        end
        S_EVT: begin
          // hold a due send while the other bank still drains
          if (!(send_fire && inflight_r)) begin
            state_r       <= S_PUSH;
            desc_r.latest <= latest_r;
            if (avg_fire) begin
              if (avg_used_r < UW'(AVG_COUNT)) begin
                if (used_inc >= UW'(AVG_COUNT)) begin
                  desc_r.have_avg <= 1'b1;
                  avg_used_r      <= '0;
                  avg_sum_r       <= '0;
                  moving_r        <= 1'b0;
                  if (moving_n) begin
                    div_x_r    <= sum_n;
                    div_step_r <= 1'b0;
                    state_r    <= S_DIV;
                  end else begin
                    desc_r.avg_val <= 32'(cfg.stop_marker);
                  end
                end else begin
                  avg_used_r <= used_inc;
                  avg_sum_r  <= sum_n;
                  moving_r   <= moving_n;
                end
              end else begin
                avg_used_r <= '0;
              end
            end
            if (send_fire) begin
              desc_r.have_send  <= 1'b1;
              desc_r.send_count <= sppm_pkg::COUNT_W'(used_r);
              desc_r.bank       <= bank_r;
              bank_r            <= !bank_r;
              used_r            <= '0;
            end
            t_avg_r  <= (t_avg_z < cfg.avg_interval) ? t_avg_z + TW'(1) : t_avg_z;
            t_send_r <= (t_send_z < cfg.send_interval) ? t_send_z + TW'(1) : t_send_z;
            t_stop_r <= (t_stop_r < cfg.stop_timeout) ? t_stop_r + TW'(1) : t_stop_r;
            t_life_r <= (t_life_r < cfg.life_interval) ? t_life_r + TW'(1) : t_life_r;
          end
        end
        S_DIV: begin
          // multiply by the reciprocal in two halves, then take the high bits
          if (!div_step_r) begin
            div_lo_r   <= prod_lo;
            div_step_r <= 1'b1;
          end else begin
            desc_r.avg_val <= 32'(prod_sum >> (32 + RL));
            state_r        <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (q_push && desc_r.have_send) begin
            inflight_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sppm_back.sv]
// Back part: pops report descriptors and drives the result words,
// reading buffered period entries from the entry RAM.
// Depends on sppm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sppm_back #(
  parameter int ENTRY_SLOTS = sppm_pkg::ENTRY_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  output logic             q_pop,
  input  sppm_pkg::desc_t  q_desc,
  output logic [((ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1):0] ram_raddr,
  input  wire logic [31:0] ram_rdata,
  output logic             send_done,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_value,
  output logic [4:0]       out_index,
  output logic [5:0]       out_filled,
  output logic [31:0]      out_latest,
  output logic             out_last
);
  localparam int SW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;

  typedef enum logic [2:0] {B_IDLE, B_LIFE, B_AVG, B_RD, B_DAT} state_t;

  state_t          state_r;
  sppm_pkg::desc_t desc_r;
  logic [SW-1:0]   eidx_r;
  logic            ovalid_r;
  logic [1:0]      kind_r;
  logic [31:0]     value_r;
  logic [4:0]      index_r;
  logic [5:0]      filled_r;
  logic [31:0]     latest_r;
  logic            last_r;
  logic            can_load, eidx_last, load_word;

  assign can_load  = !ovalid_r || out_ready;
  assign eidx_last = (eidx_r == SW'(ENTRY_SLOTS - 1));
  assign load_word = can_load && ((state_r == B_LIFE && desc_r.have_life) ||
                                  (state_r == B_AVG && desc_r.have_avg) ||
                                  (state_r == B_DAT));
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign ram_raddr = {desc_r.bank, eidx_r};
  assign send_done = (state_r == B_DAT) && can_load && eidx_last;

  assign out_valid  = ovalid_r;
  assign out_kind   = kind_r;
  assign out_value  = value_r;
  assign out_index  = index_r;
  assign out_filled = filled_r;
  assign out_latest = latest_r;
  assign out_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
      eidx_r   <= '0;
    end else begin
      if (ovalid_r && out_ready && !load_word) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            desc_r  <= q_desc;
            eidx_r  <= '0;
            state_r <= B_LIFE;
          end
        end
        B_LIFE: begin
          if (!desc_r.have_life) begin
            state_r <= B_AVG;
          end else if (can_load) begin
            ovalid_r <= 1'b1;
            kind_r   <= sppm_pkg::KIND_LIFE;
            value_r  <= 32'(desc_r.life_val);
            index_r  <= '0;
            filled_r <= '0;
            latest_r <= desc_r.latest;
            last_r   <= !desc_r.have_avg && !desc_r.have_send;
            state_r  <= B_AVG;
          end
        end
        B_AVG: begin
          if (!desc_r.have_avg) begin
            state_r <= desc_r.have_send ? B_RD : B_IDLE;
          end else if (can_load) begin
            ovalid_r <= 1'b1;
            kind_r   <= sppm_pkg::KIND_AVG;
            value_r  <= desc_r.avg_val;
            index_r  <= '0;
            filled_r <= '0;
            latest_r <= desc_r.latest;
            last_r   <= !desc_r.have_send;
            state_r  <= desc_r.have_send ? B_RD : B_IDLE;
          end
        end
        B_RD: begin
          state_r <= B_DAT;
        end
        B_DAT: begin
          if (can_load) begin
            ovalid_r <= 1'b1;
            kind_r   <= sppm_pkg::KIND_ENTRY;
            value_r  <= (sppm_pkg::COUNT_W'(eidx_r) < desc_r.send_count) ? ram_rdata : '0;
            index_r  <= 5'(eidx_r);
            filled_r <= 6'(desc_r.send_count);
            latest_r <= desc_r.latest;
            last_r   <= eidx_last;
            if (eidx_last) begin
              state_r <= B_IDLE;
            end else begin
              eidx_r  <= eidx_r + SW'(1);
              state_r <= B_RD;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/speed_pulse_period_monitor.sv]
// Top level of the speed pulse period monitor: configuration registers,
// front part, descriptor queue, double-banked entry RAM and back part.
// Depends on sppm_pkg, sppm_front, sppm_queue, sppm_ram, sppm_back.
`timescale 1ns / 1ps
`default_nettype none
// One input word is one 2 ms sample. The front part takes a word in its idle
// state and passes it through the edge, fill, event and push states, writing
// one period entry per fill step into the entry RAM (up to 32), and does a
// reciprocal multiplication when an average completes; it takes no new word
// before it is back in idle. The back part sends each lifetime or average
// word and, after a RAM read, each buffer entry; the two parts run apart
// through a two-deep descriptor queue, and the entry RAM has two banks so a
// buffer drains while the next one fills. A word that triggers a new buffer
// emission waits in the front part until the previous emission has drained.
// No clearing pass after reset: unfilled entries read as zero by fill count.
module speed_pulse_period_monitor #(
  parameter int ENTRY_SLOTS = sppm_pkg::ENTRY_SLOTS_DEF,
  parameter int AVG_COUNT   = sppm_pkg::AVG_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // captured_period[15:0], edge_counter[31:16]
  input  wire logic [0:0]  in_tuser,   // overflow_seen[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // report_value[31:0], entry_index[36:32],
                                       // entries_filled[42:37], latest_period[74:43]
  output logic [1:0]       out_tuser,  // report_kind[1:0]
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [sppm_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int SW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int AW = SW + 1;

  sppm_pkg::cfg_t  cfg_r;
  sppm_pkg::desc_t q_in, q_out;
  logic            q_push, q_full, q_pop, q_empty;
  logic            send_done, ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;
  logic [2:0]      reg_idx;
  logic            cfg_wr;
  logic [1:0]      kind;
  logic [31:0]     value, latest;
  logic [4:0]      index;
  logic [5:0]      filled;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.avg_interval  <= sppm_pkg::RST_AVG_INTERVAL;
      cfg_r.stop_timeout  <= sppm_pkg::RST_STOP_TIMEOUT;
      cfg_r.send_interval <= sppm_pkg::RST_SEND_INTERVAL;
      cfg_r.life_interval <= sppm_pkg::RST_LIFE_INTERVAL;
      cfg_r.stop_marker   <= sppm_pkg::RST_STOP_MARKER;
      cfg_r.stop_fill     <= sppm_pkg::RST_STOP_FILL;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sppm_pkg::REG_AVG_INTERVAL:  cfg_r.avg_interval  <= cfg_pwdata[9:0];
        sppm_pkg::REG_STOP_TIMEOUT:  cfg_r.stop_timeout  <= cfg_pwdata[9:0];
        sppm_pkg::REG_SEND_INTERVAL: cfg_r.send_interval <= cfg_pwdata[9:0];
        sppm_pkg::REG_LIFE_INTERVAL: cfg_r.life_interval <= cfg_pwdata[9:0];
        sppm_pkg::REG_STOP_MARKER:   cfg_r.stop_marker   <= cfg_pwdata[23:0];
        sppm_pkg::REG_STOP_FILL:     cfg_r.stop_fill     <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sppm_pkg::REG_AVG_INTERVAL:  cfg_prdata = 32'(cfg_r.avg_interval);
      sppm_pkg::REG_STOP_TIMEOUT:  cfg_prdata = 32'(cfg_r.stop_timeout);
      sppm_pkg::REG_SEND_INTERVAL: cfg_prdata = 32'(cfg_r.send_interval);
      sppm_pkg::REG_LIFE_INTERVAL: cfg_prdata = 32'(cfg_r.life_interval);
      sppm_pkg::REG_STOP_MARKER:   cfg_prdata = 32'(cfg_r.stop_marker);
      sppm_pkg::REG_STOP_FILL:     cfg_prdata = 32'(cfg_r.stop_fill);
      default:                     cfg_prdata = '0;
    endcase
  end

  sppm_front #(.ENTRY_SLOTS(ENTRY_SLOTS), .AVG_COUNT(AVG_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_captured(in_tdata[15:0]), .in_overflow(in_tuser[0]), .in_edges(in_tdata[31:16]),
    .cfg(cfg_r),
    .q_push(q_push), .q_desc(q_in), .q_full(q_full),
    .send_done(send_done),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata)
  );

  sppm_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .empty(q_empty)
  );

  sppm_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata_r(ram_rdata)
  );

  sppm_back #(.ENTRY_SLOTS(ENTRY_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_pop(q_pop), .q_desc(q_out),
    .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
    .send_done(send_done),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_kind(kind), .out_value(value), .out_index(index),
    .out_filled(filled), .out_latest(latest), .out_last(out_tlast)
  );

  assign out_tuser = kind;
  assign out_tdata = {5'b0, latest, filled, index, value};

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("front took a second word without processing the first");

  a_entry_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser == sppm_pkg::KIND_ENTRY
      |-> out_tdata[36:32] == 5'(ENTRY_SLOTS - 1))
    else $error("buffer emission ended before the last slot");

  a_entry_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sppm_pkg::KIND_ENTRY
      |-> out_tdata[42:37] <= 6'(ENTRY_SLOTS))
    else $error("fill count beyond buffer size");

endmodule
`default_nettype wire

[verif/tb_speed_pulse_period_monitor.sv]
// Testbench for speed_pulse_period_monitor: directed table then random samples,
// with an in-bench period/average/lifetime predictor checked word by word.
// Depends on sppm_pkg and the speed_pulse_period_monitor RTL.
`timescale 1ns / 1ps
module tb_speed_pulse_period_monitor;

  localparam int SLOTS = 32;
  localparam int NAVG = 6;
  localparam int TIMEOUT_CYCLES = 2000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [4:0]  index;
    logic [5:0]  filled;
    logic [31:0] latest;
    logic        last;
  } report_t;

  typedef struct {
    logic [15:0] period;
    logic        ovf;
    logic [15:0] edges;
    int          n_exp;
    logic [1:0]  kind0;
    logic [31:0] value0;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [sppm_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #5 clk = ~clk;

  speed_pulse_period_monitor i_dut (.*);

  // predictor state
  logic [9:0]  r_avg_int, r_stop_to, r_send_int, r_life_int;
  logic [23:0] r_marker, r_fill;
  logic [7:0]  ovf_count;
  logic [15:0] prev_slow, prev_fast, life_acc;
  int          used;
  logic [31:0] entries [SLOTS];
  logic [31:0] latest;
  int          avg_used;
  logic [31:0] avg_smp [NAVG];
  logic        moving;
  logic [9:0]  t_avg, t_stop, t_send, t_life;
  logic        half;

  report_t reports_due[$];
  int errors = 0;
  int cycles = 0;
  logic sender_hold = 1'b0;

  function automatic logic [5:0] edge_step(logic [15:0] old_c, logic [15:0] now_c);
    logic [16:0] d;
    if (old_c == now_c) return 6'd0;
    d = (old_c > now_c) ? 17'(old_c - now_c) : 17'h10000 - now_c + old_c;
    return (d >= 32) ? 6'd32 : d[5:0];
  endfunction

  task automatic predictor_reset();
    r_avg_int = sppm_pkg::RST_AVG_INTERVAL; r_stop_to = sppm_pkg::RST_STOP_TIMEOUT;
    r_send_int = sppm_pkg::RST_SEND_INTERVAL; r_life_int = sppm_pkg::RST_LIFE_INTERVAL;
    r_marker = sppm_pkg::RST_STOP_MARKER; r_fill = sppm_pkg::RST_STOP_FILL;
    ovf_count = 0; prev_slow = 16'hFFFF; prev_fast = 16'hFFFF; life_acc = 0;
    used = 0; latest = 32'(sppm_pkg::RST_STOP_MARKER); avg_used = 0; moving = 0;
    foreach (entries[i]) entries[i] = 0;
    foreach (avg_smp[i]) avg_smp[i] = 0;
    t_avg = 0; t_stop = 0; t_send = 0; t_life = 0; half = 1'b1;
  endtask

  function automatic int predict_sample(logic [15:0] cap, logic ovf, logic [15:0] cnt);
    logic [31:0] val, sum, avg_val, life_val;
    logic [5:0] d;
    logic [31:0] snap [SLOTS];
    int n_snap, k;
    bit hl, ha, hs;
    report_t r;
    hl = 0; ha = 0; hs = 0; n_snap = 0; avg_val = 0; life_val = 0; k = 0;
    if (ovf && ovf_count < 8'hFF) ovf_count++;
    if (!half) begin
      if (prev_slow == cnt) begin
        if (used < SLOTS && t_stop >= r_stop_to) latest = 32'(r_marker);
      end else begin
        val = 32'(cap) + 32'(ovf_count) * 32'hFFFF + 1;
        d = edge_step(prev_slow, cnt);
        for (int i = 0; i < d && used < SLOTS; i++) entries[used++] = val;
        latest = val; ovf_count = 0; t_stop = 0;
      end
      prev_slow = cnt;
    end
    half = ~half;
    life_acc = life_acc + 16'(edge_step(prev_fast, cnt));
    if (t_life >= r_life_int) begin
      hl = 1; life_val = 32'(life_acc); life_acc = 0; t_life = 0;
    end
    prev_fast = cnt;
    if (t_avg >= r_avg_int) begin
      if (avg_used < NAVG) begin
        if (latest == 32'(r_marker)) avg_smp[avg_used] = 32'(r_fill);
        else begin
          avg_smp[avg_used] = latest; moving = 1;
        end
        avg_used++;
        if (avg_used >= NAVG) begin
          if (moving) begin
            sum = 0;
            for (int i = 0; i < avg_used; i++) sum += avg_smp[i];
            avg_val = sum / avg_used;
          end else avg_val = 32'(r_marker);
          ha = 1; avg_used = 0; moving = 0;
          foreach (avg_smp[i]) avg_smp[i] = 0;
        end
      end else avg_used = 0;
      t_avg = 0;
    end
    if (t_send >= r_send_int) begin
      hs = 1; snap = entries; n_snap = used;
      foreach (entries[i]) entries[i] = 0;
      used = 0; t_send = 0;
    end
    if (t_avg < r_avg_int) t_avg++;
    if (t_stop < r_stop_to) t_stop++;
    if (t_send < r_send_int) t_send++;
    if (t_life < r_life_int) t_life++;
    if (hl) begin
      r = '{sppm_pkg::KIND_LIFE, life_val, 5'd0, 6'd0, latest, 1'b0};
      reports_due.push_back(r); k++;
    end
    if (ha) begin
      r = '{sppm_pkg::KIND_AVG, avg_val, 5'd0, 6'd0, latest, 1'b0};
      reports_due.push_back(r); k++;
    end
    if (hs)
      for (int i = 0; i < SLOTS; i++) begin
        r = '{sppm_pkg::KIND_ENTRY, snap[i], 5'(i), 6'(n_snap), latest, 1'b0};
        reports_due.push_back(r); k++;
      end
    if (k > 0) reports_due[$].last = 1'b1;
    return k;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= sppm_pkg::CFG_AW'(idx) << 2; cfg_pwdata <= val;
    @(negedge clk) cfg_penable <= 1;
    @(negedge clk) begin
      cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    end
    case (idx)
      sppm_pkg::REG_AVG_INTERVAL:  r_avg_int = val[9:0];
      sppm_pkg::REG_STOP_TIMEOUT:  r_stop_to = val[9:0];
      sppm_pkg::REG_SEND_INTERVAL: r_send_int = val[9:0];
      sppm_pkg::REG_LIFE_INTERVAL: r_life_int = val[9:0];
      sppm_pkg::REG_STOP_MARKER:   r_marker = val[23:0];
      sppm_pkg::REG_STOP_FILL:     r_fill = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    while (reports_due.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic send_sample(logic [15:0] cap, logic ovf, logic [15:0] cnt,
                             int n_exp = -1, logic [1:0] kind0 = 0, logic [31:0] v0 = 0);
    int k, first;
    in_tvalid <= 1; in_tdata <= {cnt, cap}; in_tuser <= ovf;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    first = reports_due.size();
    k = predict_sample(cap, ovf, cnt);
    if (n_exp >= 0 && k != n_exp) begin
      $error("result count expected %0d actual %0d", n_exp, k); errors++;
    end
    if (n_exp > 0 && k > 0 && (reports_due[first].kind != kind0 ||
        reports_due[first].value != v0)) begin
      $error("report_value expected %0h actual %0h", v0, reports_due[first].value); errors++;
    end
    @(negedge clk);
  endtask

  // burst/gap sender pacing
  int burst_left = 0;
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // output checking
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[31:0], out_tdata[36:32], out_tdata[42:37],
              out_tdata[74:43], out_tlast};
      if (reports_due.size() == 0) begin
        $error("unexpected word kind %0d value %0h", got.kind, got.value); errors++;
      end else begin
        want = reports_due.pop_front();
        if (got.kind != want.kind) begin
          $error("report_kind expected %0d actual %0d", want.kind, got.kind); errors++;
        end
        if (got.value != want.value) begin
          $error("report_value expected %0h actual %0h", want.value, got.value); errors++;
        end
        if (got.index != want.index) begin
          $error("entry_index expected %0d actual %0d", want.index, got.index); errors++;
        end
        if (got.filled != want.filled) begin
          $error("entries_filled expected %0d actual %0d", want.filled, got.filled); errors++;
        end
        if (got.latest != want.latest) begin
          $error("latest_period expected %0h actual %0h", want.latest, got.latest); errors++;
        end
        if (got.last != want.last) begin
          $error("last_of_run expected %0d actual %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  // receiver stall pattern: periodic windows plus random drops
  always @(negedge clk) begin
    if ((cycles / 500) % 4 == 3) out_tready <= 1'b1;
    else out_tready <= ((cycles % 7) < 5) && ($urandom_range(0, 9) != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  row_t plan [] = '{
    '{16'h0000, 1'b0, 16'hFFFF, 0, sppm_pkg::KIND_LIFE, 0},
    '{16'h1234, 1'b0, 16'hFFFE, 0, sppm_pkg::KIND_LIFE, 0},
    '{16'hFFFF, 1'b1, 16'hFFFA, 0, sppm_pkg::KIND_LIFE, 0},
    '{16'hFFFF, 1'b1, 16'hFFFA, 0, sppm_pkg::KIND_LIFE, 0},
    '{16'h0001, 1'b0, 16'hFFF0, 0, sppm_pkg::KIND_LIFE, 0},
    '{16'h0000, 1'b0, 16'hFFF0, 1, sppm_pkg::KIND_LIFE, 32'd15},
    '{16'h8000, 1'b0, 16'h0005, -1, sppm_pkg::KIND_LIFE, 0},
    '{16'h7FFF, 1'b1, 16'h0010, -1, sppm_pkg::KIND_LIFE, 0},
    '{16'hFFFF, 1'b0, 16'h0000, -1, sppm_pkg::KIND_LIFE, 0},
    '{16'h0000, 1'b0, 16'hFFFF, -1, sppm_pkg::KIND_LIFE, 0},
    '{16'hAAAA, 1'b0, 16'h5555, -1, sppm_pkg::KIND_LIFE, 0},
    '{16'h5555, 1'b1, 16'hAAAA, -1, sppm_pkg::KIND_LIFE, 0}
  };

  logic [15:0] edge_now;
  int mode;

  initial begin
    predictor_reset();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (plan[i])
      send_sample(plan[i].period, plan[i].ovf, plan[i].edges, plan[i].n_exp,
                  plan[i].kind0, plan[i].value0);
    in_tvalid <= 0;
    drain_and_settle();
    // every register, extremes; fast intervals so averages and standstill happen
    write_reg(sppm_pkg::REG_AVG_INTERVAL, 1);
    write_reg(sppm_pkg::REG_STOP_TIMEOUT, 1);
    write_reg(sppm_pkg::REG_SEND_INTERVAL, 1023);
    write_reg(sppm_pkg::REG_LIFE_INTERVAL, 1023);
    write_reg(sppm_pkg::REG_STOP_MARKER, 32'h00FFFFFF);
    write_reg(sppm_pkg::REG_STOP_FILL, 0);
    edge_now = 16'hFFFF;
    for (int i = 0; i < 20; i++)
      send_sample(16'h0100, 1'b0, edge_now, -1);
    in_tvalid <= 0;
    drain_and_settle();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(sppm_pkg::REG_AVG_INTERVAL, ph == 0 ? 1 : $urandom_range(1, 8));
      write_reg(sppm_pkg::REG_STOP_TIMEOUT, ph == 1 ? 1023 : $urandom_range(1, 12));
      write_reg(sppm_pkg::REG_SEND_INTERVAL, ph == 0 ? 1 : $urandom_range(1, 30));
      write_reg(sppm_pkg::REG_LIFE_INTERVAL, ph == 2 ? 1 : $urandom_range(1, 10));
      write_reg(sppm_pkg::REG_STOP_MARKER, ph == 3 ? 0 : $urandom_range(0, 24'hFFFFFF));
      write_reg(sppm_pkg::REG_STOP_FILL, ph == 3 ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF));
      for (int i = 0; i < 110; i++) begin
        pace();
        if (ph == 2 && i == 55) begin
          in_tvalid <= 0;
          sender_hold = 1'b1;
          while (reports_due.size() != 0) @(negedge clk);
          @(negedge clk);
          sender_hold = 1'b0;
        end
        mode = $urandom_range(0, 9);
        if (mode < 4) edge_now = edge_now - 16'($urandom_range(1, 3));
        else if (mode < 6) edge_now = edge_now - 16'($urandom_range(20, 60));
        else if (mode == 6) edge_now = 16'($urandom);
        send_sample(16'($urandom), $urandom_range(0, 3) == 0, edge_now, -1);
      end
      in_tvalid <= 0;
      drain_and_settle();
    end
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
